### rtl/core/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the sorted insert table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int EMIT_MAX    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_READOUT = 1'b1;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_ENTRY    = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic               command;
        logic signed [15:0] key;
        logic [31:0]        payload;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] key_out;
        logic [31:0]        payload_out;
        logic               last;
    } out_item_t;

    // head of the request queue as seen by the back part
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } queue_head_t;

endpackage

### rtl/core/sorted_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_insert_table
// Sorted key/payload table with insert and in-order readout requests.
// ----------------------------------------------------------------------------
// usage:
//   requests enter through push/full with an item of command, key, payload;
//   results leave through empty/pop, the oldest one shown while empty is low
//   insert: one result (inserted, or full when the table holds DEPTH entries)
//   readout: one result per stored entry in ascending key order, equal keys
//   in arrival order, last set on the final one; an empty table gives one
//   empty result
//   an insert result shows in the cycle after the request is taken; the
//   first readout entry passes the read state, then the result register
//   throughput: one insert per cycle while results are popped; a readout
//   holds the table engine until its last entry, one entry per cycle while popped
//   a two-deep request queue sits ahead of the engine, so requests are taken
//   while a result waits; when pop stays low the engine stops after one
//   held result and full rises once the queue fills
//   reset clears the entry count, the queue and the result valid flag; stored
//   entries need no clearing, since only entries below the count are read
// ----------------------------------------------------------------------------
module sorted_insert_table
    import sit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    queue_head_t head;
    logic        take;

    sit_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .head  (head),
        .take  (take)
    );

    sit_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

### rtl/core/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front
// Accepts requests and holds them in a short queue for the table engine.
// ----------------------------------------------------------------------------
module sit_front
    import sit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output queue_head_t head,
    input  logic        take
);

    in_item_t           q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               wr_en;
    logic               rd_en;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    always_comb
    begin
        full        = (cnt_reg == Q_CNT_W'(Q_DEPTH));
        wr_en       = push && !full;
        rd_en       = take && (cnt_reg != '0);
        head.valid  = (cnt_reg != '0);
        head.item   = q_reg[rd_ptr_reg];
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

### rtl/core/sit_back.sv
// ----------------------------------------------------------------------------
// sit_back
// Table engine: shift-chain insert by parallel compares, sequenced readout,
// and the result register.
// ----------------------------------------------------------------------------
module sit_back
    import sit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        take,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_reg;
    out_item_t          out_next;

    logic signed [15:0] keys_reg [DEPTH];
    logic [31:0]        pays_reg [DEPTH];
    logic signed [15:0] keys_ins [DEPTH];
    logic [31:0]        pays_ins [DEPTH];
    logic [DEPTH-1:0]   moved;
    logic               ins_en;
    logic               out_ok;
    logic [CNT_W-1:0]   emit_n;
    logic               rd_last;

    // moved[i]: slot i lies at or after the insert position, up to the first free slot
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            moved[i] = ((CNT_W'(i) < count_reg) && (keys_reg[i] > head.item.key))
                       || (CNT_W'(i) == count_reg);
        end
        keys_ins[0] = moved[0] ? head.item.key : keys_reg[0];
        pays_ins[0] = moved[0] ? head.item.payload : pays_reg[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            if (moved[i] && !moved[i-1])
            begin
                keys_ins[i] = head.item.key;
                pays_ins[i] = head.item.payload;
            end
            else if (moved[i])
            begin
                keys_ins[i] = keys_reg[i-1];
                pays_ins[i] = pays_reg[i-1];
            end
            else
            begin
                keys_ins[i] = keys_reg[i];
                pays_ins[i] = pays_reg[i];
            end
        end
    end

    always_comb
    begin
        out_ok  = !out_valid_reg || pop;
        take    = (state_reg == S_IDLE) && head.valid && out_ok;
        emit_n  = (count_reg > CNT_W'(EMIT_MAX)) ? CNT_W'(EMIT_MAX) : count_reg;
        rd_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == emit_n);

        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        ins_en         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    out_next.key_out     = '0;
                    out_next.payload_out = '0;
                    out_next.last        = 1'b1;
                    if (head.item.command == CMD_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            out_next.status = STAT_FULL;
                        end
                        else
                        begin
                            out_next.status = STAT_INSERTED;
                            ins_en          = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        state_next  = S_READ;
                        rd_idx_next = '0;
                    end
                end
            end
            S_READ:
            begin
                if (out_ok)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = STAT_ENTRY;
                    out_next.key_out     = keys_reg[rd_idx_reg];
                    out_next.payload_out = pays_reg[rd_idx_reg];
                    out_next.last        = rd_last;
                    if (rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        empty  = !out_valid_reg;
        result = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (ins_en)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                keys_reg[i] <= keys_ins[i];
                pays_reg[i] <= pays_ins[i];
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_read_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> $stable(count_reg))
        else $error("table changed during readout");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (count_reg != '0)
            && (CNT_W'(rd_idx_reg) < emit_n))
        else $error("readout index beyond stored entries");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> $stable(out_reg))
        else $error("waiting result overwritten");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (take && head.item.command == CMD_INSERT && count_reg == CNT_W'(DEPTH))
            |=> (result.status == STAT_FULL) && $stable(count_reg))
        else $error("insert into full table not refused");

endmodule

### bench/tb_sorted_insert_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_insert_table
// Self-checking bench for the sorted insert table: a behavioral copy of the
// table predicts every result, and each popped result is compared field by
// field with the oldest prediction, under random push bursts and pop stalls.
// ----------------------------------------------------------------------------
module tb_sorted_insert_table;

    timeunit 1ns;
    timeprecision 1ps;

    import sit_pkg::*;

    localparam int RANDOM_REQUESTS = 430;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      full;
    in_item_t  item  = '0;
    logic      empty;
    logic      pop   = 1'b0;
    out_item_t result;

    // behavioral copy of the table
    logic signed [15:0] model_keys[DEPTH];
    logic [31:0]        model_payloads[DEPTH];
    int                 model_count = 0;

    out_item_t pending_results[$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int entries_stored  = 0;
    int inserts_refused = 0;
    int readouts_sent   = 0;

    // sender pacing
    int burst_left = 0;
    bit no_gaps    = 1'b0;

    // receiver pacing
    int rx_mode  = 0;
    int rx_left  = 0;
    int rx_phase = 0;

    sorted_insert_table i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic out_item_t make_result(logic [1:0] status, logic signed [15:0] k,
                                              logic [31:0] p, logic is_last);
        out_item_t r;
        r.status      = status;
        r.key_out     = k;
        r.payload_out = p;
        r.last        = is_last;
        return r;
    endfunction

    function automatic void predict_table_response(in_item_t req);
        int pos;
        int emit;
        if (req.command == CMD_INSERT)
        begin
            if (model_count >= DEPTH)
            begin
                pending_results.push_back(make_result(STAT_FULL, '0, '0, 1'b1));
                inserts_refused++;
            end
            else
            begin
                // new entry goes after every key that is equal or smaller
                pos = 0;
                while (pos < model_count && model_keys[pos] <= req.key)
                    pos++;
                for (int i = model_count; i > pos; i--)
                begin
                    model_keys[i]     = model_keys[i - 1];
                    model_payloads[i] = model_payloads[i - 1];
                end
                model_keys[pos]     = req.key;
                model_payloads[pos] = req.payload;
                model_count++;
                entries_stored++;
                pending_results.push_back(make_result(STAT_INSERTED, '0, '0, 1'b1));
            end
        end
        else
        begin
            readouts_sent++;
            if (model_count == 0)
            begin
                pending_results.push_back(make_result(STAT_EMPTY, '0, '0, 1'b1));
            end
            else
            begin
                emit = (model_count < MAX_RESULTS) ? model_count : MAX_RESULTS;
                for (int i = 0; i < emit; i++)
                    pending_results.push_back(make_result(STAT_ENTRY, model_keys[i],
                                                          model_payloads[i], i == emit - 1));
            end
        end
    endfunction

    task automatic pause_sender(int cycles);
        in_item_t junk;
        junk.command = 1'($urandom);
        junk.key     = 16'($urandom);
        junk.payload = $urandom;
        @(negedge clk);
        push <= 1'b0;
        item <= junk;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_request(logic cmd, logic signed [15:0] k, logic [31:0] p);
        in_item_t req;
        req.command = cmd;
        req.key     = k;
        req.payload = p;
        @(negedge clk);
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_table_response(req);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if (!no_gaps)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_readout();
        send_request(CMD_READOUT, 16'sh8000, 32'hFFFF_FFFF);
        send_request(CMD_READOUT, 16'sh7FFF, 32'h0000_0000);
    endtask

    task automatic test_extreme_keys();
        send_request(CMD_INSERT, 16'sh8000, 32'h0000_0000);
        send_request(CMD_INSERT, 16'sh7FFF, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 16'sh0000, 32'hA5A5_A5A5);
        send_request(CMD_INSERT, -16'sd1,   32'h5A5A_5A5A);
        send_request(CMD_READOUT, '0, '0);
    endtask

    task automatic test_equal_keys();
        // equal keys must come back in arrival order
        send_request(CMD_INSERT, 16'sd100,  32'h0000_0001);
        send_request(CMD_INSERT, 16'sd100,  32'h0000_0002);
        send_request(CMD_INSERT, 16'sd100,  32'h0000_0003);
        send_request(CMD_INSERT, -16'sd1,   32'h0000_0004);
        send_request(CMD_INSERT, 16'sh7FFF, 32'h0000_0005);
        send_request(CMD_READOUT, '0, '0);
    endtask

    task automatic test_table_full();
        while (model_count < DEPTH)
            send_request(CMD_INSERT, 16'($signed($urandom_range(0, 8)) - 4), $urandom);
        send_request(CMD_INSERT, 16'sh8000, $urandom);
        send_request(CMD_INSERT, 16'sh7FFF, $urandom);
        send_request(CMD_READOUT, '0, '0);
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 50 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_request(1'($urandom), 16'($urandom), $urandom);
        end
    endtask

    // receiver: stall pattern changes every so often
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom);
                2:       pop <= ($urandom_range(0, 4) == 0);
                default: pop <= rx_phase[2];
            endcase
        end
    end

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result with no request pending, got %p", $time, result);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("status",      32'(want.status),          32'(result.status));
                report_field("key_out",     32'(16'(want.key_out)),    32'(16'(result.key_out)));
                report_field("payload_out", want.payload_out,          result.payload_out);
                report_field("last",        32'(want.last),            32'(result.last));
                results_checked++;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(1, 8);

        test_empty_readout();
        test_extreme_keys();
        test_equal_keys();
        test_table_full();
        test_random_traffic();

        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d requests: %0d entries stored, %0d inserts refused, %0d readouts",
                 requests_sent, entries_stored, inserts_refused, readouts_sent);
        $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
